// ===== rtl/core/gctm_pkg.sv =====
`timescale 1ns / 1ps
package gctm_pkg;

  localparam int MAX_GEARS = 8;
  localparam int ADDR_W    = 6;
  localparam int DATA_W    = 64;

  // Register indexes, taken from paddr[5:3].
  localparam logic [2:0] REG_GEAR_COUNT   = 3'd0;
  localparam logic [2:0] REG_FINAL_DRIVE  = 3'd1;
  localparam logic [2:0] REG_RATIOS_LOW   = 3'd2;
  localparam logic [2:0] REG_RATIOS_HIGH  = 3'd3;
  localparam logic [2:0] REG_LOCK_THRESH  = 3'd4;
  localparam logic [2:0] REG_SLIP_GAIN    = 3'd5;
  localparam logic [2:0] REG_MAX_TORQUE   = 3'd6;
  localparam logic [2:0] REG_TICK_RATE    = 3'd7;

  localparam logic [1:0] SHIFT_UP   = 2'd1;
  localparam logic [1:0] SHIFT_DOWN = 2'd2;

  localparam logic signed [3:0] GEAR_REV     = -4'sd2;
  localparam logic signed [3:0] GEAR_NEUTRAL = -4'sd1;

  // 2*pi/60 in Q0.24 and the 0.06 smoothing factor in Q0.16.
  localparam logic [20:0] OMEGA_K    = 21'd1756906;
  localparam logic [11:0] SMOOTH_K   = 12'd3932;
  localparam logic [24:0] RATE_CLAMP = 25'd32768000;

  localparam logic [20:0] BITE_LO_E10 = 21'd393216;
  localparam logic [20:0] BITE_HI_E10 = 21'd589824;
  localparam logic [16:0] ENG_FULL    = 17'd65536;

  typedef struct packed {
    logic [3:0]  gear_count;
    logic [15:0] final_drive;
    logic [63:0] ratios_low;
    logic [63:0] ratios_high;
    logic [16:0] lock_threshold;
    logic [31:0] slip_gain;
    logic [30:0] max_torque;
    logic [16:0] tick_rate;
  } cfg_t;

  function automatic logic signed [31:0] sat32s(input logic signed [63:0] v);
    logic signed [31:0] res;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      res = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      res = 32'sh8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/gctm_regs.sv =====
`timescale 1ns / 1ps
module gctm_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gctm_pkg::ADDR_W-1:0] paddr,
  input  logic [gctm_pkg::DATA_W-1:0] pwdata,
  output logic [gctm_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output gctm_pkg::cfg_t             cfg
);
  import gctm_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[ADDR_W-1:3];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_GEAR_COUNT:  cfg_nxt.gear_count     = pwdata[3:0];
        REG_FINAL_DRIVE: cfg_nxt.final_drive    = pwdata[15:0];
        REG_RATIOS_LOW:  cfg_nxt.ratios_low     = pwdata;
        REG_RATIOS_HIGH: cfg_nxt.ratios_high    = pwdata;
        REG_LOCK_THRESH: cfg_nxt.lock_threshold = pwdata[16:0];
        REG_SLIP_GAIN:   cfg_nxt.slip_gain      = pwdata[31:0];
        REG_MAX_TORQUE:  cfg_nxt.max_torque     = pwdata[30:0];
        REG_TICK_RATE:   cfg_nxt.tick_rate      = pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_GEAR_COUNT:  prdata = {60'd0, cfg_r.gear_count};
      REG_FINAL_DRIVE: prdata = {48'd0, cfg_r.final_drive};
      REG_RATIOS_LOW:  prdata = cfg_r.ratios_low;
      REG_RATIOS_HIGH: prdata = cfg_r.ratios_high;
      REG_LOCK_THRESH: prdata = {47'd0, cfg_r.lock_threshold};
      REG_SLIP_GAIN:   prdata = {32'd0, cfg_r.slip_gain};
      REG_MAX_TORQUE:  prdata = {33'd0, cfg_r.max_torque};
      REG_TICK_RATE:   prdata = {47'd0, cfg_r.tick_rate};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gear_count     <= 4'd6;
      cfg_r.final_drive    <= 16'd14336;
      cfg_r.ratios_low     <= '0;
      cfg_r.ratios_high    <= '0;
      cfg_r.lock_threshold <= 17'd62259;
      cfg_r.slip_gain      <= 32'd655360;
      cfg_r.max_torque     <= 31'd26214400;
      cfg_r.tick_rate      <= 17'd1000;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== rtl/core/gctm_mul.sv =====
`timescale 1ns / 1ps
module gctm_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [31:0] b,
  input  logic [5:0]  nbits,
  output logic [63:0] prod,
  output logic        done
);
  // Shift-add multiplier: one bit of b per cycle, LSB first.
  logic [63:0] a_r, acc_r;
  logic [31:0] b_r;
  logic [5:0]  cnt_r;
  logic        run_r, done_r;

  assign prod = acc_r;
  assign done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= nbits;
      end else if (run_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (run_r) begin
      if (b_r[0]) begin
        acc_r <= acc_r + a_r;
      end
      a_r <= {a_r[62:0], 1'b0};
      b_r <= {1'b0, b_r[31:1]};
    end
  end

endmodule

// ===== rtl/core/gctm_div.sv =====
`timescale 1ns / 1ps
module gctm_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  input  logic [5:0]  nbits,
  output logic [63:0] quotient,
  output logic        done
);
  // Restoring divider, one quotient bit per cycle. The dividend arrives
  // left aligned, so its top nbits bits are consumed from bit 63 down.
  logic [63:0] num_r, quo_r;
  logic [31:0] den_r, rem_r;
  logic [5:0]  cnt_r;
  logic        run_r, done_r;
  logic [32:0] shifted;
  logic [33:0] dif;

  assign shifted  = {rem_r, num_r[63]};
  assign dif      = {1'b0, shifted} - {2'b00, den_r};
  assign quotient = quo_r;
  assign done     = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= nbits;
      end else if (run_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      den_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (run_r) begin
      num_r <= {num_r[62:0], 1'b0};
      if (!dif[33]) begin
        rem_r <= dif[31:0];
        quo_r <= {quo_r[62:0], 1'b1};
      end else begin
        rem_r <= shifted[31:0];
        quo_r <= {quo_r[62:0], 1'b0};
      end
    end
  end

endmodule

// ===== rtl/core/gearbox_clutch_torque_model_core.sv =====
`timescale 1ns / 1ps
// Each item runs its serial steps on one shared shift-add multiplier and one restoring divider;
// fewer steps run with the clutch open or in neutral, the most in locking mode with a nonzero ratio.
// One item at a time; the next item is taken once the result is registered.
// Reset (rst_n, synchronous): neutral gear, full engagement, zero clutch torque and slip,
// registers at their defaults, no result pending.
module gearbox_clutch_torque_model_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_clutch_held,
  input  logic [1:0]                  in_shift_request,
  input  logic signed [31:0]          in_engine_torque_in,
  input  logic [23:0]                 in_engine_rpm,
  input  logic signed [31:0]          in_wheel_speed,
  input  logic signed [31:0]          in_wheel_side_torque,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [31:0]          out_wheel_torque,
  output logic signed [31:0]          out_engine_net_torque,
  output logic signed [31:0]          out_load_torque,
  output logic signed [3:0]           out_gear_now,
  output logic                        out_shift_done,
  output logic signed [31:0]          out_slip_speed,
  output logic signed [31:0]          out_clutch_torque_out,
  output logic [16:0]                 out_engagement_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gctm_pkg::ADDR_W-1:0] paddr,
  input  logic [gctm_pkg::DATA_W-1:0] pwdata,
  output logic [gctm_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import gctm_pkg::*;

  typedef enum logic [13:0] {
    ST_IDLE   = 14'b00000000000001,
    ST_RMUL   = 14'b00000000000010,
    ST_EO     = 14'b00000000000100,
    ST_TOMUL  = 14'b00000000001000,
    ST_BITE   = 14'b00000000010000,
    ST_TG1    = 14'b00000000100000,
    ST_RATE   = 14'b00000001000000,
    ST_TG2    = 14'b00000010000000,
    ST_TMAX   = 14'b00000100000000,
    ST_SMOOTH = 14'b00001000000000,
    ST_WHEEL  = 14'b00010000000000,
    ST_LOAD   = 14'b00100000000000,
    ST_STEP   = 14'b01000000000000,
    ST_DONE   = 14'b10000000000000
  } state_t;

  cfg_t cfg;

  state_t state_r, state_nxt;
  logic   go_r, go_nxt;

  // Captured item and architectural state.
  logic               held_r, held_nxt;
  logic               done_r, done_nxt;
  logic signed [31:0] eng_t_r, eng_t_nxt;
  logic [23:0]        rpm_r, rpm_nxt;
  logic signed [31:0] ws_r, ws_nxt;
  logic signed [31:0] wst_r, wst_nxt;
  logic signed [3:0]  gear_r, gear_nxt;
  logic [16:0]        eng_r, eng_nxt;
  logic signed [31:0] ct_r, ct_nxt;
  logic signed [31:0] last_r, last_nxt;

  // Working values.
  logic [31:0]        rmag_r, rmag_nxt;
  logic               rneg_r, rneg_nxt;
  logic [28:0]        eo_r, eo_nxt;
  logic signed [31:0] slip_r, slip_nxt;
  logic [16:0]        bite_r, bite_nxt;
  logic [24:0]        rate_mag_r, rate_mag_nxt;
  logic               rate_neg_r, rate_neg_nxt;
  logic signed [51:0] tg_r, tg_nxt;
  logic signed [31:0] target_r, target_nxt;
  logic signed [31:0] wheel_r, wheel_nxt;
  logic signed [31:0] net_r, net_nxt;
  logic signed [31:0] load_r, load_nxt;

  // Result register.
  logic               ov_r, ov_nxt;
  logic signed [31:0] o_wheel_r, o_wheel_nxt, o_net_r, o_net_nxt, o_load_r, o_load_nxt;
  logic signed [3:0]  o_gear_r, o_gear_nxt;
  logic               o_done_r, o_done_nxt;
  logic signed [31:0] o_slip_r, o_slip_nxt, o_ct_r, o_ct_nxt;
  logic [16:0]        o_eng_r, o_eng_nxt;

  // Shared arithmetic units.
  logic        mul_start, div_start, op_start, is_div, op_done;
  logic [63:0] mul_a, mul_p, div_num, div_q;
  logic [31:0] mul_b, div_den;
  logic [5:0]  mul_n, div_n;
  logic        mul_done, div_done;

  // Combinational helpers.
  logic               accept;
  logic [2:0]         cnt_m1;
  logic               up_ok, down_ok;
  logic [127:0]       ratio_all;
  logic [2:0]         ratio_idx;
  logic [15:0]        ratio_sel;
  logic [31:0]        ws_mag, wst_mag, slip_mag, ct_mag;
  logic [20:0]        e10;
  logic [17:0]        e10_off;
  logic signed [32:0] diff;
  logic [32:0]        diff_mag;
  logic [33:0]        gain3;
  logic               lock;
  logic               small_ct, smooth_cond;
  logic signed [32:0] sx;
  logic [32:0]        sx_mag;
  logic signed [17:0] ed;
  logic [16:0]        ed_mag;
  logic [19:0]        edk;
  logic [16:0]        tr;
  logic [39:0]        to_mag;
  logic signed [63:0] to_s, slip_w;
  logic [47:0]        p1;
  logic [49:0]        p1x3;
  logic [49:0]        rate_prod;
  logic [46:0]        s2;
  logic signed [51:0] tsum, mxs, tmax;
  logic [31:0]        sm;
  logic signed [33:0] dlt, ct_new;
  logic [39:0]        wm;
  logic [55:0]        lq;
  logic [19:0]        sq;
  logic signed [21:0] eng_new;

  gctm_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gctm_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .nbits (mul_n),
    .prod  (mul_p),
    .done  (mul_done)
  );

  gctm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .nbits    (div_n),
    .quotient (div_q),
    .done     (div_done)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  assign out_valid             = ov_r;
  assign out_wheel_torque      = o_wheel_r;
  assign out_engine_net_torque = o_net_r;
  assign out_load_torque       = o_load_r;
  assign out_gear_now          = o_gear_r;
  assign out_shift_done        = o_done_r;
  assign out_slip_speed        = o_slip_r;
  assign out_clutch_torque_out = o_ct_r;
  assign out_engagement_out    = o_eng_r;

  // Gear limits: a count of zero acts as one, a count beyond the table as the table size.
  always_comb begin
    if (cfg.gear_count == 4'd0) begin
      cnt_m1 = 3'd0;
    end else if (cfg.gear_count > 4'(MAX_GEARS)) begin
      cnt_m1 = 3'(MAX_GEARS - 1);
    end else begin
      cnt_m1 = 3'(cfg.gear_count - 4'd1);
    end
  end

  assign up_ok   = $signed({gear_r[3], gear_r}) < $signed({2'b00, cnt_m1});
  assign down_ok = (gear_r != GEAR_REV);

  assign ratio_all = {cfg.ratios_high, cfg.ratios_low};
  assign ratio_idx = (gear_r == GEAR_REV) ? 3'd0 : gear_r[2:0];
  assign ratio_sel = (gear_r == GEAR_NEUTRAL) ? 16'd0 : ratio_all[ratio_idx*16 +: 16];

  assign ws_mag   = ws_r[31]   ? 32'(-ws_r)   : 32'(ws_r);
  assign wst_mag  = wst_r[31]  ? 32'(-wst_r)  : 32'(wst_r);
  assign slip_mag = slip_r[31] ? 32'(-slip_r) : 32'(slip_r);
  assign ct_mag   = ct_r[31]   ? 32'(-ct_r)   : 32'(ct_r);

  assign e10     = ({4'd0, eng_r} << 3) + ({4'd0, eng_r} << 1);
  assign e10_off = 18'(e10 - BITE_LO_E10);

  assign diff     = {slip_r[31], slip_r} - {last_r[31], last_r};
  assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
  assign gain3    = {2'b00, cfg.slip_gain} + {1'b0, cfg.slip_gain, 1'b0};
  assign lock     = (bite_r >= cfg.lock_threshold);

  // Smoothing moves toward the target unless the sign flips on a sizable torque,
  // in which case the torque decays by the same fraction instead.
  assign small_ct    = (ct_r > -32'sd65536) && (ct_r < 32'sd65536);
  assign smooth_cond = (ct_r[31] == target_r[31]) || small_ct;
  assign sx          = smooth_cond ? ({target_r[31], target_r} - {ct_r[31], ct_r})
                                   : {ct_r[31], ct_r};
  assign sx_mag      = sx[32] ? 33'(-sx) : 33'(sx);

  assign ed     = $signed({1'b0, (held_r ? 17'd0 : ENG_FULL)}) - $signed({1'b0, eng_r});
  assign ed_mag = ed[17] ? 17'(-ed) : 17'(ed);
  assign edk    = ed[17] ? (({3'd0, ed_mag} << 2) + ({3'd0, ed_mag} << 1))
                         : (({3'd0, ed_mag} << 3) + ({3'd0, ed_mag} << 2));
  assign tr     = (cfg.tick_rate == 17'd0) ? 17'd1 : cfg.tick_rate;

  // Result fields of the unit outputs.
  assign to_mag    = mul_p[63:24];
  assign to_s      = $signed({24'd0, to_mag});
  assign slip_w    = (ws_r[31] ^ rneg_r) ? ($signed({35'd0, eo_r}) + to_s)
                                         : ($signed({35'd0, eo_r}) - to_s);
  assign p1        = mul_p[63:16];
  assign p1x3      = {2'b00, p1} + {1'b0, p1, 1'b0};
  assign rate_prod = mul_p[49:0];
  assign s2        = mul_p[63:17];
  assign tsum      = tg_r + (rate_neg_r ? -$signed({5'd0, s2}) : $signed({5'd0, s2}));
  assign mxs       = $signed({21'd0, cfg.max_torque});
  assign tmax      = $signed({20'd0, mul_p[47:16]});
  assign sm        = mul_p[47:16];
  assign dlt       = sx[32] ? -$signed({2'b00, sm}) : $signed({2'b00, sm});
  assign ct_new    = smooth_cond ? ($signed({{2{ct_r[31]}}, ct_r}) + dlt)
                                 : ($signed({{2{ct_r[31]}}, ct_r}) - dlt);
  assign wm        = mul_p[63:24];
  assign lq        = div_q[55:0];
  assign sq        = div_q[19:0];
  assign eng_new   = $signed({5'd0, eng_r})
                   + (ed[17] ? -$signed({2'b00, sq}) : $signed({2'b00, sq}));

  // Operand selection for the shared units.
  assign is_div    = (state_r == ST_BITE) || (state_r == ST_LOAD) || (state_r == ST_STEP);
  assign op_start  = !go_r && (state_r != ST_IDLE) && (state_r != ST_DONE);
  assign mul_start = op_start && !is_div;
  assign div_start = op_start && is_div;
  assign op_done   = mul_done || div_done;

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_n   = '0;
    div_num = '0;
    div_den = '0;
    div_n   = '0;
    unique case (state_r)
      ST_RMUL: begin
        mul_a = {48'd0, ratio_sel};
        mul_b = {16'd0, cfg.final_drive};
        mul_n = 6'd16;
      end
      ST_EO: begin
        mul_a = {40'd0, rpm_r};
        mul_b = {11'd0, OMEGA_K};
        mul_n = 6'd21;
      end
      ST_TOMUL: begin
        mul_a = {32'd0, ws_mag};
        mul_b = rmag_r;
        mul_n = 6'd32;
      end
      ST_BITE: begin
        div_num = {e10_off, 46'd0};
        div_den = 32'd3;
        div_n   = 6'd18;
      end
      ST_TG1: begin
        mul_a = {32'd0, slip_mag};
        mul_b = cfg.slip_gain;
        mul_n = 6'd32;
      end
      ST_RATE: begin
        mul_a = {31'd0, diff_mag};
        mul_b = {15'd0, cfg.tick_rate};
        mul_n = 6'd17;
      end
      ST_TG2: begin
        mul_a = {30'd0, gain3};
        mul_b = {7'd0, rate_mag_r};
        mul_n = 6'd25;
      end
      ST_TMAX: begin
        mul_a = {33'd0, cfg.max_torque};
        mul_b = {15'd0, bite_r};
        mul_n = 6'd17;
      end
      ST_SMOOTH: begin
        mul_a = {31'd0, sx_mag};
        mul_b = {20'd0, SMOOTH_K};
        mul_n = 6'd12;
      end
      ST_WHEEL: begin
        mul_a = {32'd0, ct_mag};
        mul_b = rmag_r;
        mul_n = 6'd32;
      end
      ST_LOAD: begin
        div_num = {wst_mag, 32'd0};
        div_den = rmag_r;
        div_n   = 6'd56;
      end
      ST_STEP: begin
        div_num = {edk, 44'd0};
        div_den = {15'd0, tr};
        div_n   = 6'd20;
      end
      default: ;
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt    = state_r;
    go_nxt       = go_r;
    held_nxt     = held_r;
    done_nxt     = done_r;
    eng_t_nxt    = eng_t_r;
    rpm_nxt      = rpm_r;
    ws_nxt       = ws_r;
    wst_nxt      = wst_r;
    gear_nxt     = gear_r;
    eng_nxt      = eng_r;
    ct_nxt       = ct_r;
    last_nxt     = last_r;
    rmag_nxt     = rmag_r;
    rneg_nxt     = rneg_r;
    eo_nxt       = eo_r;
    slip_nxt     = slip_r;
    bite_nxt     = bite_r;
    rate_mag_nxt = rate_mag_r;
    rate_neg_nxt = rate_neg_r;
    tg_nxt       = tg_r;
    target_nxt   = target_r;
    wheel_nxt    = wheel_r;
    net_nxt      = net_r;
    load_nxt     = load_r;
    ov_nxt       = ov_r && !out_ready;
    o_wheel_nxt  = o_wheel_r;
    o_net_nxt    = o_net_r;
    o_load_nxt   = o_load_r;
    o_gear_nxt   = o_gear_r;
    o_done_nxt   = o_done_r;
    o_slip_nxt   = o_slip_r;
    o_ct_nxt     = o_ct_r;
    o_eng_nxt    = o_eng_r;

    if (op_start) begin
      go_nxt = 1'b1;
    end else if (op_done) begin
      go_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          held_nxt  = in_clutch_held;
          eng_t_nxt = in_engine_torque_in;
          rpm_nxt   = in_engine_rpm;
          ws_nxt    = in_wheel_speed;
          wst_nxt   = in_wheel_side_torque;
          done_nxt  = 1'b0;
          if (in_clutch_held && (in_shift_request == SHIFT_UP) && up_ok) begin
            gear_nxt = gear_r + 4'sd1;
            done_nxt = 1'b1;
          end else if (in_clutch_held && (in_shift_request == SHIFT_DOWN) && down_ok) begin
            gear_nxt = gear_r - 4'sd1;
            done_nxt = 1'b1;
          end
          state_nxt = ST_RMUL;
        end
      end
      ST_RMUL: begin
        if (op_done) begin
          rmag_nxt  = mul_p[31:0];
          rneg_nxt  = (gear_r == GEAR_REV);
          state_nxt = ST_EO;
        end
      end
      ST_EO: begin
        if (op_done) begin
          eo_nxt    = mul_p[44:16];
          state_nxt = ST_TOMUL;
        end
      end
      ST_TOMUL: begin
        if (op_done) begin
          slip_nxt = sat32s(slip_w);
          if ((gear_r == GEAR_NEUTRAL) || held_r) begin
            ct_nxt    = '0;
            last_nxt  = (gear_r == GEAR_NEUTRAL) ? 32'sd0 : sat32s(slip_w);
            wheel_nxt = '0;
            net_nxt   = eng_t_r;
            load_nxt  = '0;
            state_nxt = ST_STEP;
          end else if (e10 < BITE_LO_E10) begin
            bite_nxt  = '0;
            state_nxt = ST_TG1;
          end else if (e10 > BITE_HI_E10) begin
            bite_nxt  = ENG_FULL;
            state_nxt = ST_TG1;
          end else begin
            state_nxt = ST_BITE;
          end
        end
      end
      ST_BITE: begin
        if (op_done) begin
          bite_nxt  = div_q[16:0];
          state_nxt = ST_TG1;
        end
      end
      ST_TG1: begin
        if (op_done) begin
          if (lock) begin
            tg_nxt    = slip_r[31] ? -$signed({2'b00, p1x3}) : $signed({2'b00, p1x3});
            state_nxt = ST_RATE;
          end else begin
            tg_nxt    = slip_r[31] ? -$signed({4'd0, p1}) : $signed({4'd0, p1});
            state_nxt = ST_TMAX;
          end
        end
      end
      ST_RATE: begin
        if (op_done) begin
          rate_mag_nxt = (rate_prod > {25'd0, RATE_CLAMP}) ? RATE_CLAMP : rate_prod[24:0];
          rate_neg_nxt = diff[32];
          state_nxt    = ST_TG2;
        end
      end
      ST_TG2: begin
        if (op_done) begin
          if (tsum > mxs) begin
            target_nxt = mxs[31:0];
          end else if (tsum < -mxs) begin
            target_nxt = 32'(-mxs);
          end else begin
            target_nxt = tsum[31:0];
          end
          state_nxt = ST_SMOOTH;
        end
      end
      ST_TMAX: begin
        if (op_done) begin
          if (tg_r > tmax) begin
            target_nxt = tmax[31:0];
          end else if (tg_r < -tmax) begin
            target_nxt = 32'(-tmax);
          end else begin
            target_nxt = tg_r[31:0];
          end
          state_nxt = ST_SMOOTH;
        end
      end
      ST_SMOOTH: begin
        if (op_done) begin
          ct_nxt    = ct_new[31:0];
          last_nxt  = slip_r;
          state_nxt = ST_WHEEL;
        end
      end
      ST_WHEEL: begin
        if (op_done) begin
          wheel_nxt = sat32s((ct_r[31] ^ rneg_r) ? -$signed({24'd0, wm})
                                                 : $signed({24'd0, wm}));
          net_nxt   = sat32s($signed({{32{eng_t_r[31]}}, eng_t_r})
                           - $signed({{32{ct_r[31]}}, ct_r}));
          if (rmag_r == 32'd0) begin
            load_nxt  = '0;
            state_nxt = ST_STEP;
          end else begin
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        if (op_done) begin
          load_nxt  = sat32s((wst_r[31] ^ rneg_r) ? -$signed({8'd0, lq})
                                                  : $signed({8'd0, lq}));
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        if (op_done) begin
          if (eng_new < 22'sd0) begin
            eng_nxt = '0;
          end else if (eng_new > $signed({5'd0, ENG_FULL})) begin
            eng_nxt = ENG_FULL;
          end else begin
            eng_nxt = eng_new[16:0];
          end
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!ov_r || out_ready) begin
          ov_nxt      = 1'b1;
          o_wheel_nxt = wheel_r;
          o_net_nxt   = net_r;
          o_load_nxt  = load_r;
          o_gear_nxt  = gear_r;
          o_done_nxt  = done_r;
          o_slip_nxt  = last_r;
          o_ct_nxt    = ct_r;
          o_eng_nxt   = eng_r;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      go_r    <= 1'b0;
      ov_r    <= 1'b0;
      gear_r  <= GEAR_NEUTRAL;
      eng_r   <= ENG_FULL;
      ct_r    <= '0;
      last_r  <= '0;
    end else begin
      state_r <= state_nxt;
      go_r    <= go_nxt;
      ov_r    <= ov_nxt;
      gear_r  <= gear_nxt;
      eng_r   <= eng_nxt;
      ct_r    <= ct_nxt;
      last_r  <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r     <= held_nxt;
    done_r     <= done_nxt;
    eng_t_r    <= eng_t_nxt;
    rpm_r      <= rpm_nxt;
    ws_r       <= ws_nxt;
    wst_r      <= wst_nxt;
    rmag_r     <= rmag_nxt;
    rneg_r     <= rneg_nxt;
    eo_r       <= eo_nxt;
    slip_r     <= slip_nxt;
    bite_r     <= bite_nxt;
    rate_mag_r <= rate_mag_nxt;
    rate_neg_r <= rate_neg_nxt;
    tg_r       <= tg_nxt;
    target_r   <= target_nxt;
    wheel_r    <= wheel_nxt;
    net_r      <= net_nxt;
    load_r     <= load_nxt;
    o_wheel_r  <= o_wheel_nxt;
    o_net_r    <= o_net_nxt;
    o_load_r   <= o_load_nxt;
    o_gear_r   <= o_gear_nxt;
    o_done_r   <= o_done_nxt;
    o_slip_r   <= o_slip_nxt;
    o_ct_r     <= o_ct_nxt;
    o_eng_r    <= o_eng_nxt;
  end

endmodule
